// ===== rtl/int32_to_float32_rne_defines.svh =====
// Assertion macros used by the converter top module.
// Depends on nothing; included by files that assert.
`ifndef INT32_TO_FLOAT32_RNE_DEFINES_SVH
`define INT32_TO_FLOAT32_RNE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define I2F_ASSERT_IMP(label, clk_s, rst_s, lhs, rhs) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define I2F_ASSERT_NEXT(label, clk_s, rst_s, lhs, rhs) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== rtl/i2f_pkg.sv =====
// Constants and stage types for the int32 to float32 converter.
// Depends on nothing.
package i2f_pkg;
  localparam int unsigned INT_W  = 32;
  localparam int unsigned FLT_W  = 32;
  localparam int unsigned FRAC_W = 23;
  localparam int unsigned POS_W  = 5;
  localparam logic [7:0]  EXP_BIAS = 8'h7F;

  typedef struct packed {
    logic             sign;
    logic [INT_W-1:0] mag;
  } s1_t;

  typedef struct packed {
    logic             sign;
    logic             zero;
    logic [POS_W-1:0] top;
    logic [INT_W-1:0] norm;
  } s2_t;
endpackage

// ===== rtl/i2f_stream_if.sv =====
// Valid/ready stream interface carrying one 32-bit word.
// Depends on nothing.
interface i2f_stream_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2f_norm.sv =====
// Leading-one search and left alignment of the magnitude.
// Depends on i2f_pkg.
module i2f_norm (
  input  i2f_pkg::s1_t in_s,
  output i2f_pkg::s2_t out_s
);
  import i2f_pkg::*;
  logic [POS_W-1:0] pos;
  always_comb begin
    pos = '0;
    for (int k = 0; k < INT_W; k++) begin
      if (in_s.mag[k]) pos = POS_W'(k);
    end
    out_s.sign = in_s.sign;
    out_s.zero = (in_s.mag == '0);
    out_s.top  = pos;
    out_s.norm = in_s.mag << (POS_W'(INT_W - 1) - pos);
  end
endmodule

// ===== rtl/i2f_round.sv =====
// Round to nearest even and pack the IEEE single word.
// Depends on i2f_pkg.
module i2f_round (
  input  i2f_pkg::s2_t      in_s,
  output logic [31:0]       word
);
  import i2f_pkg::*;
  logic [FRAC_W:0] sig;
  logic [FRAC_W+1:0] sum;
  logic guard, sticky, up;
  logic [7:0] expo;
  always_comb begin
    sig    = in_s.norm[INT_W-1 -: FRAC_W+1];
    guard  = in_s.norm[INT_W-FRAC_W-2];
    sticky = |in_s.norm[INT_W-FRAC_W-3:0];
    up     = guard && (sticky || sig[0]);
    sum    = {1'b0, sig} + (FRAC_W+2)'(up);
    expo   = 8'(in_s.top) + EXP_BIAS + 8'(sum[FRAC_W+1]);
    if (in_s.zero) word = '0;
    else if (sum[FRAC_W+1]) word = {in_s.sign, expo, FRAC_W'(0)};
    else word = {in_s.sign, expo, sum[FRAC_W-1:0]};
  end
endmodule

// ===== rtl/int32_to_float32_rne.sv =====
// Converts signed 32-bit integers to IEEE 754 single, round to nearest even.
// Three register stages: magnitude, normalize, round; one word per cycle
// while float_word.ready holds, and the stages stall under back-pressure.
// Depends on i2f_pkg, i2f_stream_if, i2f_norm, i2f_round and the defines header.
`include "int32_to_float32_rne_defines.svh"
module int32_to_float32_rne (
  input logic clk,
  input logic rst,
  i2f_stream_if.sink   int_value,
  i2f_stream_if.source float_word
);
  import i2f_pkg::*;
  logic v1, v2, v3, adv1, adv2, adv3;
  s1_t  r1;
  s2_t  r2, n2;
  logic [31:0] r3, n3;

  assign adv3 = !v3 || float_word.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign int_value.ready = adv1;
  assign float_word.valid = v3;
  assign float_word.data  = r3;

  i2f_norm  u_norm (.in_s(r1), .out_s(n2));
  i2f_round u_round (.in_s(r2), .word(n3));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= int_value.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) begin
      r1.sign <= int_value.data[INT_W-1];
      r1.mag  <= int_value.data[INT_W-1] ? (INT_W'(0) - int_value.data) : int_value.data;
    end
    if (adv2) r2 <= n2;
    if (adv3) r3 <= n3;
  end

  `I2F_ASSERT_NEXT(a_hold, clk, rst, v3 && !float_word.ready, v3 && $stable(r3))
  `I2F_ASSERT_IMP(a_zero, clk, rst, v2 && r2.zero && adv3, n3 == '0)
  `I2F_ASSERT_NEXT(a_flow, clk, rst, v2 && adv3, v3)
endmodule

// ===== verif/int32_to_float32_rne_tb.sv =====
// Self-checking bench for the int32 to float32 converter, round to nearest even.
// Drives integers through i2f_stream_if, predicts each float word, checks in order.
// Depends on i2f_pkg, i2f_stream_if and int32_to_float32_rne.
module int32_to_float32_rne_tb;
  import i2f_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2f_stream_if int_value (.clk(clk));
  i2f_stream_if float_word (.clk(clk));

  int32_to_float32_rne DUT (
    .clk(clk),
    .rst(rst),
    .int_value(int_value.sink),
    .float_word(float_word.source)
  );

  always #4 clk = ~clk;

  logic [FLT_W-1:0] pending_floats[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      quiet_cycles  = 0;
  bit               failed        = 1'b0;

  initial begin
    int_value.valid  = 1'b0;
    int_value.data   = '0;
    float_word.ready = 1'b0;
  end

  function automatic logic [FLT_W-1:0] to_float(input logic [INT_W-1:0] word);
    logic             sign;
    logic [INT_W-1:0] mag;
    logic [INT_W-1:0] rest;
    logic [INT_W-1:0] half;
    logic [24:0]      sig;
    logic [7:0]       expo;
    int               top;
    int               drop;
    sign = word[INT_W-1];
    mag  = sign ? (~word + 1'b1) : word;
    if (mag == '0) return '0;
    top = 0;
    for (int k = 0; k < INT_W; k++) if (mag[k]) top = k;
    expo = EXP_BIAS + 8'(top);
    if (top <= FRAC_W) begin
      sig = 25'(mag << (FRAC_W - top));
    end else begin
      drop = top - FRAC_W;
      sig  = 25'(mag >> drop);
      rest = mag & ((32'd1 << drop) - 1);
      half = 32'd1 << (drop - 1);
      if (rest > half || (rest == half && sig[0])) sig = sig + 1'b1;
      if (sig[24]) begin
        sig  = sig >> 1;
        expo = expo + 1'b1;
      end
    end
    return {sign, expo, sig[FRAC_W-1:0]};
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      float_word.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((int_value.valid && int_value.ready) || (float_word.valid && float_word.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("int32_to_float32_rne_tb NOT OK");
        $finish;
      end
      if (float_word.valid && float_word.ready) begin
        if (pending_floats.size() == 0) begin
          $display("%0t: unexpected float word, expected none, actual %h",
                   $time, float_word.data);
          failed <= 1'b1;
        end else begin
          if (float_word.data !== pending_floats[0]) begin
            $display("%0t: float word mismatch, expected %h, actual %h",
                     $time, pending_floats[0], float_word.data);
            failed <= 1'b1;
          end
          void'(pending_floats.pop_front());
        end
      end
    end
  end

  task automatic send_int(input logic [INT_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      int_value.valid <= 1'b0;
      @(posedge clk);
    end
    int_value.valid <= 1'b1;
    int_value.data  <= value;
    pending_floats.push_back(to_float(value));
    do @(posedge clk); while (!int_value.ready);
  endtask

  task automatic test_extremes();
    send_int(32'h0000_0000);
    send_int(32'h8000_0000);
    send_int(32'h7FFF_FFFF);
    send_int(32'hFFFF_FFFF);
    send_int(32'h0000_0001);
    send_int(32'h00FF_FFFF);
    send_int(32'h0100_0000);
    send_int(32'h5555_5555);
    send_int(32'hAAAA_AAAA);
  endtask

  task automatic test_rounding();
    send_int(32'h0100_0001);
    send_int(32'h0100_0003);
    send_int(32'h0100_0002);
    send_int(32'h01FF_FFFF);
    send_int(32'h7FFF_FFC0);
    send_int(32'h7FFF_FF40);
    send_int(32'h7FFF_FF80);
    send_int(32'h8000_0080);
    send_int(32'hFEFF_FFFF);
    send_int(32'h0300_0004);
  endtask

  task automatic test_random(input int unsigned count);
    logic [INT_W-1:0] value;
    int               width;
    for (int i = 0; i < count; i++) begin
      value = $urandom;
      width = $urandom_range(32, 1);
      case ($urandom_range(3))
        0: value = value >> (32 - width);
        1: value = -(value >> (32 - width));
        2: value = (value & 32'hFFFF_FF00) |
                   32'({1'($urandom_range(1)), 7'h40 + 7'($urandom_range(1))});
        default: ;
      endcase
      send_int(value);
    end
  endtask

  task automatic drain();
    int_value.valid <= 1'b0;
    while (pending_floats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_rounding();
    send_idle_pct = 14;
    recv_idle_pct = 85;
    test_random(340);
    send_idle_pct = 85;
    recv_idle_pct = 14;
    test_random(340);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    drain();
    if (!failed)
      $display("int32_to_float32_rne_tb OK");
    else
      $display("int32_to_float32_rne_tb NOT OK");
    $finish;
  end
endmodule
